// ----- hw/rtl/eba_pkg.sv -----
// shared types, constants and action codes of the energy budget accountant
package eba_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int SRC_IDX_W   = $clog2(NUM_SOURCES);
  localparam int ID_EXT_W    = 9;

  localparam int ENERGY_W  = 48;
  localparam int POWER_W   = 24;
  localparam int TOTAL_W   = 29;
  localparam int TIME_W    = 32;
  localparam int PRODUCT_W = TIME_W + TOTAL_W;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 48;

  localparam logic [ENERGY_W-1:0] INITIAL_ENERGY_RST = 48'd18720000000000;
  localparam logic [POWER_W-1:0]  BASELINE_POWER_RST = 24'd6000;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ENERGY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_POWER = 8'd1;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_TICK    = 3'd1;
  localparam logic [2:0] ACT_SET_PWR = 3'd2;
  localparam logic [2:0] ACT_QUERY   = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [TIME_W-1:0]  now_ms;
    logic [3:0]         source_id;
    logic [POWER_W-1:0] source_power;
  } eba_in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] remaining_energy;
    logic [ENERGY_W-1:0] spent_energy;
    logic [TOTAL_W-1:0]  total_power;
    logic                energy_depleted;
    logic                accounting_disabled;
  } eba_out_t;

  typedef struct packed {
    logic                 en;
    logic [SRC_IDX_W-1:0] addr;
    logic [POWER_W-1:0]   data;
  } eba_tbl_wr_t;

  typedef struct packed {
    logic                exhausted;
    logic [ENERGY_W-1:0] remaining;
  } eba_drain_res_t;

endpackage

// ----- hw/rtl/eba_table_mem.sv -----
// per-source power table: synchronous ram with valid bits, unwritten entries read as zero
module eba_table_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [eba_pkg::SRC_IDX_W-1:0]  rd_addr,
  output logic [eba_pkg::POWER_W-1:0]    rd_data,
  input  eba_pkg::eba_tbl_wr_t           wr
);

  logic [eba_pkg::POWER_W-1:0]     mem [eba_pkg::NUM_SOURCES];
  logic [eba_pkg::NUM_SOURCES-1:0] valid_r;
  logic [eba_pkg::POWER_W-1:0]     rdata_r;
  logic                            rvalid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

// ----- hw/rtl/eba_drain_unit.sv -----
// drain datapath: elapsed time, registered power product, clamp against remaining energy
module eba_drain_unit (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [eba_pkg::TIME_W-1:0]    now_ms,
  input  logic [eba_pkg::TIME_W-1:0]    last_time,
  input  logic [eba_pkg::TOTAL_W-1:0]   total_power,
  input  logic [eba_pkg::ENERGY_W-1:0]  remaining,
  output eba_pkg::eba_drain_res_t       res
);

  logic [eba_pkg::TIME_W-1:0]    elapsed_r;
  logic [eba_pkg::PRODUCT_W-1:0] product_r;
  logic [eba_pkg::PRODUCT_W-1:0] remaining_ext;

  // elapsed wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (load) begin
      elapsed_r <= now_ms - last_time;
    end
    if (step) begin
      product_r <= eba_pkg::PRODUCT_W'(elapsed_r) * eba_pkg::PRODUCT_W'(total_power);
    end
  end

  assign remaining_ext = eba_pkg::PRODUCT_W'(remaining);

  always_comb begin
    if (remaining_ext <= product_r) begin
      res.exhausted = 1'b1;
      res.remaining = '0;
    end else begin
      res.exhausted = 1'b0;
      res.remaining = remaining - product_r[eba_pkg::ENERGY_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/energy_budget_accountant_unit.sv -----
// top level of the energy budget accountant: sequencer, accounting state and ports
//
// tracks a node's energy budget in nanojoules from a millisecond timestamp and
// per-source powers in microwatts, so elapsed time times total power is exact
// energy. every input transaction yields exactly one result transaction. for
// each item, the accept cycle computes elapsed time and reads the power table,
// the next forms the 32 by 29 bit power product in one registered multiplier,
// and the last clamps against the remaining energy, writes the table entry
// back and loads the output register. a new item is taken in the cycle after
// that, even while the previous result still waits at the output; the final
// cycle holds only while the output register is occupied and out_ready is low.
// the power table lives in a small synchronous ram whose entries read as zero
// until written, so no clearing pass follows reset. configuration writes are
// always taken (cfg_ready is tied high); register 0 is the initial energy and
// register 1 the baseline power. neither feeds the accounting state (it resets
// to constants), while spent energy always uses the current initial energy register
module energy_budget_accountant_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  eba_pkg::eba_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output eba_pkg::eba_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [eba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eba_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // configuration registers
  logic [eba_pkg::ENERGY_W-1:0] init_energy_r;
  logic [eba_pkg::POWER_W-1:0]  baseline_r;

  // accounting state
  logic [eba_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [eba_pkg::ENERGY_W-1:0] remaining_r, remaining_nxt;
  logic [eba_pkg::TIME_W-1:0]   last_time_r, last_time_nxt;
  logic                         started_r, started_nxt;
  logic                         disabled_r, disabled_nxt;
  logic                         oof;

  // item in flight
  eba_pkg::eba_in_t             item_r;
  logic [eba_pkg::ID_EXT_W-1:0] item_id_ext;
  logic                         item_in_range;
  logic [eba_pkg::ID_EXT_W-1:0] in_id_ext;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  eba_pkg::eba_out_t            out_data_r, out_data_nxt;

  logic                         in_fire;
  logic                         commit;
  logic                         want_drain;
  logic [eba_pkg::POWER_W-1:0]  old_power;
  eba_pkg::eba_tbl_wr_t         tbl_wr;
  eba_pkg::eba_drain_res_t      drain_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign commit    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign in_id_ext     = {5'b0, in_data.source_id};
  assign item_id_ext   = {5'b0, item_r.source_id};
  assign item_in_range = item_id_ext < eba_pkg::ID_EXT_W'(eba_pkg::NUM_SOURCES);

  eba_table_mem u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_id_ext[eba_pkg::SRC_IDX_W-1:0]),
    .rd_data (old_power),
    .wr      (tbl_wr)
  );

  // last_time and total are stable while an item is in flight
  eba_drain_unit u_drain (
    .clk         (clk),
    .load        (in_fire),
    .step        (state_r == ST_MUL),
    .now_ms      (in_data.now_ms),
    .last_time   (last_time_r),
    .total_power (total_r),
    .remaining   (remaining_r),
    .res         (drain_res)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // action decode and state update in the final cycle
  always_comb begin
    want_drain    = 1'b0;
    remaining_nxt = remaining_r;
    last_time_nxt = last_time_r;
    started_nxt   = started_r;
    disabled_nxt  = disabled_r;
    total_nxt     = total_r;
    oof           = 1'b0;
    tbl_wr.en     = 1'b0;
    tbl_wr.addr   = item_id_ext[eba_pkg::SRC_IDX_W-1:0];
    tbl_wr.data   = item_r.source_power;

    case (item_r.action)
      eba_pkg::ACT_START: begin
        disabled_nxt  = 1'b0;
        started_nxt   = 1'b1;
        last_time_nxt = item_r.now_ms;
      end
      eba_pkg::ACT_TICK:    want_drain = started_r;
      eba_pkg::ACT_SET_PWR: want_drain = !disabled_r;
      eba_pkg::ACT_QUERY:   want_drain = !disabled_r;
      eba_pkg::ACT_DESTROY: disabled_nxt = 1'b1;
      default: ;
    endcase

    // no drain once the energy is gone
    if (want_drain && (remaining_r != '0)) begin
      last_time_nxt = item_r.now_ms;
      remaining_nxt = drain_res.remaining;
      if (drain_res.exhausted) begin
        oof          = 1'b1;
        disabled_nxt = 1'b1;
      end
    end

    // source replaced in the total, wrapping modulo 2^29
    if ((item_r.action == eba_pkg::ACT_SET_PWR) && item_in_range) begin
      total_nxt = total_r - eba_pkg::TOTAL_W'(old_power)
                + eba_pkg::TOTAL_W'(item_r.source_power);
      tbl_wr.en = commit;
    end

    out_data_nxt.remaining_energy    = remaining_nxt;
    out_data_nxt.spent_energy        = init_energy_r - remaining_nxt;
    out_data_nxt.total_power         = total_nxt;
    out_data_nxt.energy_depleted     = oof;
    out_data_nxt.accounting_disabled = disabled_nxt;
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      init_energy_r <= eba_pkg::INITIAL_ENERGY_RST;
      baseline_r    <= eba_pkg::BASELINE_POWER_RST;
      total_r       <= eba_pkg::TOTAL_W'(eba_pkg::BASELINE_POWER_RST);
      remaining_r   <= eba_pkg::INITIAL_ENERGY_RST;
      last_time_r   <= '0;
      started_r     <= 1'b0;
      disabled_r    <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        total_r     <= total_nxt;
        remaining_r <= remaining_nxt;
        last_time_r <= last_time_nxt;
        started_r   <= started_nxt;
        disabled_r  <= disabled_nxt;
      end
      // baseline is never read, kept for the register map
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          eba_pkg::REG_INITIAL_ENERGY: init_energy_r <= cfg_data[eba_pkg::ENERGY_W-1:0];
          eba_pkg::REG_BASELINE_POWER: baseline_r    <= cfg_data[eba_pkg::POWER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
